// ----- hdl/assert_macros.svh -----
// assertion helpers, all checks sample on clk and are off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge
`define CHK_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: invariant");

// antecedent implies consequent in the next cycle
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: sequence");

`endif

// ----- hdl/cksr_pkg.sv -----
`default_nettype none
package cksr_pkg;

  localparam int MAX_ITERATIONS_DEF = 10;
  localparam int FRACTION_BITS_DEF  = 24;

  localparam int IN_W  = 24;
  localparam int OUT_W = 16;
  localparam int CFG_W = 16;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_RADIUS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STOP_TOL   = 1'd1;

  localparam logic [CFG_W-1:0] MAX_RADIUS_RST = 16'd4096;
  localparam logic [CFG_W-1:0] STOP_TOL_RST   = 16'd17;

endpackage
`default_nettype wire

// ----- hdl/cubic_kernel_radius_sampler_core.sv -----
`default_nettype none
// Samples a radius from a cubic falloff kernel: the uniform input is mapped through the
// inverse CDF by Newton iteration (start at x = 0.25, at most MAX_ITERATIONS steps, early
// exit on residual below stop_tolerance or zero slope), then radius = x * max_radius and
// height = sqrt(max_radius^2 - radius^2) come out together as one item. One item is in
// flight at a time. Each Newton step runs seven passes through the one shared multiplier,
// then evaluate, check, a one-bit-per-cycle divider and update; a step of two or more
// skips the divider, and an early exit leaves after the check. The tail does three
// multiplies, a square root and the output load. With the defaults a full run is ten steps.
// The user must ensure max_radius and stop_tolerance are written only while idle; the
// block itself does not enforce it.
module cubic_kernel_radius_sampler_core #(
  parameter int MAX_ITERATIONS = cksr_pkg::MAX_ITERATIONS_DEF,
  parameter int FRACTION_BITS  = cksr_pkg::FRACTION_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  [cksr_pkg::IN_W-1:0]            in_uniform_value,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [cksr_pkg::OUT_W-1:0]           out_radius,
  output logic [cksr_pkg::OUT_W-1:0]           out_height,
  input  wire                                  cfg_write_en,
  input  wire  [cksr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire  [cksr_pkg::CFG_W-1:0]           cfg_data
);
  import cksr_pkg::*;

  localparam int F   = FRACTION_BITS;
  localparam int FW  = F + 7;
  localparam int PW  = 2 * F + 2;
  localparam int CW  = $clog2(F);
  localparam int IW  = $clog2(MAX_ITERATIONS + 1);
  localparam int UP  = (F >= IN_W) ? F - IN_W : 0;
  localparam int DN  = (F >= IN_W) ? 0 : IN_W - F;
  localparam logic [F:0] ONE = (F + 1)'(1) << F;

  typedef enum logic [4:0] {
    ST_IDLE, ST_X2, ST_X3, ST_X4, ST_X5, ST_A, ST_B, ST_C, ST_EVAL, ST_CHECK,
    ST_DIV, ST_UPD, ST_RAD, ST_MM, ST_RR, ST_SQRT, ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_radius_r, out_radius_nxt, out_height_r, out_height_nxt;
  logic [CFG_W-1:0] max_radius_r, max_radius_nxt, stop_tol_r, stop_tol_nxt;
  logic [IW-1:0] iter_r, iter_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic [F:0] x_r, x_nxt, x2_r, x2_nxt, x3_r, x3_nxt, x4_r, x4_nxt, x5_r, x5_nxt;
  logic [F:0] a_r, a_nxt, b_r, b_nxt;
  logic [F-1:0] u_r, u_nxt;
  logic [F+2:0] fd_r, fd_nxt;
  logic signed [FW-1:0] f_r, f_nxt;
  logic [F+2:0] rem_r, rem_nxt;
  logic [F+1:0] q_r, q_nxt;
  logic [OUT_W-1:0] r_r, r_nxt;
  logic [31:0] mm_r, mm_nxt, sqv_r, sqv_nxt, res_r, res_nxt;

  // shared multiplier
  logic [F:0] mul_a, mul_b;
  logic [PW-1:0] prod;
  logic [F:0] psh;
  assign prod = mul_a * mul_b;
  assign psh  = prod[2*F:F];

  logic [F:0] nx;
  assign nx = ONE - x_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_X2:   begin mul_a = x_r;  mul_b = x_r;  end
      ST_X3:   begin mul_a = x2_r; mul_b = x_r;  end
      ST_X4:   begin mul_a = x2_r; mul_b = x2_r; end
      ST_X5:   begin mul_a = x2_r; mul_b = x3_r; end
      ST_A:    begin mul_a = x_r;  mul_b = nx;   end
      ST_B:    begin mul_a = nx;   mul_b = nx;   end
      ST_C:    begin mul_a = a_r;  mul_b = b_r;  end
      ST_RAD:  begin mul_a = x_r;  mul_b = (F + 1)'(max_radius_r); end
      ST_MM:   begin mul_a = (F + 1)'(max_radius_r); mul_b = (F + 1)'(max_radius_r); end
      ST_RR:   begin mul_a = (F + 1)'(r_r); mul_b = (F + 1)'(r_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // residual terms
  logic [FW-1:0] t_pos, t_neg, af;
  assign t_pos = (FW'(x2_r) << 3) + (FW'(x2_r) << 1) + (FW'(x4_r) << 4) - FW'(x4_r);
  assign t_neg = (FW'(x3_r) << 4) + (FW'(x3_r) << 2) + (FW'(x5_r) << 2) + FW'(u_r);
  assign af = f_r[FW-1] ? FW'(-f_r) : FW'(f_r);

  logic [F+3:0] rem2;
  logic         div_bit;
  assign rem2    = {rem_r, 1'b0};
  assign div_bit = rem2 >= (F + 4)'(fd_r);

  logic [F+1:0] xe;
  assign xe = (F + 2)'(x_r);

  logic [16:0] r_full;
  assign r_full = prod[F+16:F];

  logic [31:0] sq_bit, sq_t;
  assign sq_bit = 32'(1) << (5'(30) - {cnt_r[3:0], 1'b0});
  assign sq_t   = res_r + sq_bit;

  logic [IN_W+UP-1:0] u_up;
  assign u_up = (IN_W + UP)'(in_uniform_value) << UP;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_radius_nxt = out_radius_r;
    out_height_nxt = out_height_r;
    max_radius_nxt = max_radius_r;
    stop_tol_nxt   = stop_tol_r;
    iter_nxt = iter_r;
    cnt_nxt  = cnt_r;
    x_nxt  = x_r;  x2_nxt = x2_r; x3_nxt = x3_r; x4_nxt = x4_r; x5_nxt = x5_r;
    a_nxt  = a_r;  b_nxt  = b_r;  u_nxt  = u_r;  fd_nxt = fd_r; f_nxt  = f_r;
    rem_nxt = rem_r; q_nxt = q_r; r_nxt = r_r;
    mm_nxt = mm_r; sqv_nxt = sqv_r; res_nxt = res_r;

    if (cfg_write_en) begin
      unique case (cfg_index)
        REG_MAX_RADIUS: max_radius_nxt = cfg_data;
        REG_STOP_TOL:   stop_tol_nxt   = cfg_data;
        default:        ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          u_nxt     = F'(u_up >> DN);
          x_nxt     = ONE >> 2;
          iter_nxt  = '0;
          state_nxt = ST_X2;
        end
      end
      ST_X2: begin x2_nxt = psh; state_nxt = ST_X3; end
      ST_X3: begin x3_nxt = psh; state_nxt = ST_X4; end
      ST_X4: begin x4_nxt = psh; state_nxt = ST_X5; end
      ST_X5: begin x5_nxt = psh; state_nxt = ST_A;  end
      ST_A:  begin a_nxt  = psh; state_nxt = ST_B;  end
      ST_B:  begin b_nxt  = psh; state_nxt = ST_C;  end
      ST_C: begin
        fd_nxt    = (F + 3)'({psh, 4'b0}) + (F + 3)'({psh, 2'b0});
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        f_nxt     = $signed(t_pos) - $signed(t_neg);
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (af < FW'(stop_tol_r) || fd_r == '0) begin
          state_nxt = ST_RAD;
        end else if (af >= FW'({fd_r, 1'b0})) begin
          // step of two or more clamps x anyway
          q_nxt     = (F + 2)'(1) << (F + 1);
          state_nxt = ST_UPD;
        end else if (af >= FW'(fd_r)) begin
          rem_nxt   = (F + 3)'(af - FW'(fd_r));
          q_nxt     = (F + 2)'(1);
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end else begin
          rem_nxt   = (F + 3)'(af);
          q_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = div_bit ? (F + 3)'(rem2 - (F + 4)'(fd_r)) : (F + 3)'(rem2);
        q_nxt   = {q_r[F:0], div_bit};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(F - 1)) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (f_r > 0) begin
          x_nxt = (q_r >= xe) ? '0 : (F + 1)'(xe - q_r);
        end else begin
          x_nxt = (q_r >= (F + 2)'(nx)) ? ONE : (F + 1)'(xe + q_r);
        end
        if (iter_r == IW'(MAX_ITERATIONS - 1)) begin
          state_nxt = ST_RAD;
        end else begin
          iter_nxt  = iter_r + 1'b1;
          state_nxt = ST_X2;
        end
      end
      ST_RAD: begin
        r_nxt     = (r_full > {1'b0, max_radius_r}) ? max_radius_r : r_full[15:0];
        state_nxt = ST_MM;
      end
      ST_MM: begin
        mm_nxt    = prod[31:0];
        state_nxt = ST_RR;
      end
      ST_RR: begin
        sqv_nxt   = mm_r - prod[31:0];
        res_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        if (sqv_r >= sq_t) begin
          sqv_nxt = sqv_r - sq_t;
          res_nxt = (res_r >> 1) + sq_bit;
        end else begin
          res_nxt = res_r >> 1;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(15)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_radius_nxt = r_r;
          out_height_nxt = res_r[15:0];
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      max_radius_r <= MAX_RADIUS_RST;
      stop_tol_r   <= STOP_TOL_RST;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      max_radius_r <= max_radius_nxt;
      stop_tol_r   <= stop_tol_nxt;
    end
    out_radius_r <= out_radius_nxt;
    out_height_r <= out_height_nxt;
  end

  always_ff @(posedge clk) begin
    iter_r <= iter_nxt;
    cnt_r  <= cnt_nxt;
    x_r  <= x_nxt;  x2_r <= x2_nxt; x3_r <= x3_nxt; x4_r <= x4_nxt; x5_r <= x5_nxt;
    a_r  <= a_nxt;  b_r  <= b_nxt;  u_r  <= u_nxt;
    fd_r <= fd_nxt; f_r  <= f_nxt;  rem_r <= rem_nxt; q_r <= q_nxt;
    r_r  <= r_nxt;  mm_r <= mm_nxt; sqv_r <= sqv_nxt; res_r <= res_nxt;
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_radius = out_radius_r;
  assign out_height = out_height_r;

`include "assert_macros.svh"

  `CHK_ALWAYS(a_x_in_range, state_r == ST_IDLE || x_r <= ONE)
  `CHK_ALWAYS(a_rem_below_divisor, state_r != ST_DIV || rem_r < fd_r)
  `CHK_ALWAYS(a_radius_le_max, state_r != ST_MM || r_r <= max_radius_r)
  `CHK_NEXT(a_accept_starts, in_valid && !in_stall, state_r == ST_X2)

endmodule
`default_nettype wire

// ----- verif/tb_cubic_kernel_radius_sampler_core.sv -----
`timescale 1ns / 1ps
module tb_cubic_kernel_radius_sampler_core;
  import cksr_pkg::*;

  localparam int FB = 24;
  localparam int NEWTON_STEPS = 10;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [15:0] radius;
    logic [15:0] height;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [IN_W-1:0] in_uniform_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [OUT_W-1:0] out_radius;
  logic [OUT_W-1:0] out_height;
  logic cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_MAX_RADIUS;
  logic [CFG_W-1:0] cfg_data = '0;

  logic [15:0] max_radius = MAX_RADIUS_RST;
  logic [15:0] stop_tolerance = STOP_TOL_RST;
  sample_t pending_samples[$];
  int fail_count = 0;
  int idle_cycles = 0;
  int out_wait = -1;

  cubic_kernel_radius_sampler_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_uniform_value(in_uniform_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_radius(out_radius), .out_height(out_height),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[FB+63:FB];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 30;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic sample_t sample_radius(logic [23:0] uval);
    logic [63:0] one, x, nx, x2, x3, x4, x5, fd, af, q0, rem, frac, delta, r, mr, h;
    logic signed [63:0] f;
    sample_t s;
    one = 64'd1 << FB;
    x = one >> 2;
    for (int i = 0; i < NEWTON_STEPS; i++) begin
      nx = one - x;
      x2 = qmul(x, x);
      x3 = qmul(x2, x);
      x4 = qmul(x2, x2);
      x5 = qmul(x2, x3);
      f = $signed(10 * x2 + 15 * x4) - $signed(20 * x3 + 4 * x5) - $signed({40'd0, uval});
      fd = 20 * qmul(qmul(x, nx), qmul(nx, nx));
      af = (f < 0) ? -f : f;
      if (af < {48'd0, stop_tolerance} || fd == 0) break;
      q0 = af / fd;
      if (q0 >= 2) begin
        delta = 2 * one;
      end else begin
        rem = af - q0 * fd;
        frac = 0;
        for (int b = 0; b < FB; b++) begin
          rem = rem << 1;
          frac = frac << 1;
          if (rem >= fd) begin
            rem = rem - fd;
            frac[0] = 1'b1;
          end
        end
        delta = (q0 << FB) | frac;
      end
      if (f > 0) x = (delta >= x) ? 0 : x - delta;
      else x = (delta >= one - x) ? one : x + delta;
    end
    mr = {48'd0, max_radius};
    r = (x * mr) >> FB;
    if (r > mr) r = mr;
    if (r > 64'hFFFF) r = 64'hFFFF;
    h = int_sqrt(mr * mr - r * r);
    if (h > 64'hFFFF) h = 64'hFFFF;
    s.radius = r[15:0];
    s.height = h[15:0];
    return s;
  endfunction

  // valid stays up between items when no idle cycles are drawn
  task automatic send_uniform(logic [23:0] uval);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_uniform_value <= uval;
    pending_samples.push_back(sample_radius(uval));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
    drain_and_settle();
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    if (idx == REG_MAX_RADIUS) max_radius = val;
    else stop_tolerance = val;
  endtask

  // receiver draws a hold-off for each result item and stalls the output until it runs out
  always @(negedge clk) begin
    if (rst_n && out_valid) begin
      if (out_wait < 0) out_wait = $urandom_range(0, 4);
      if (out_wait > 0) begin
        out_stall <= 1'b1;
        out_wait = out_wait - 1;
      end else begin
        out_stall <= 1'b0;
        out_wait = -1;
      end
    end
  end

  always @(posedge clk) begin
    sample_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        $error("result item with no expectation waiting");
        fail_count++;
      end else begin
        want = pending_samples.pop_front();
        if (out_radius !== want.radius) begin
          $error("radius mismatch: expected %0d actual %0d", want.radius, out_radius);
          fail_count++;
        end
        if (out_height !== want.height) begin
          $error("height mismatch: expected %0d actual %0d", want.height, out_height);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_input_extremes();
    send_uniform(24'd0);
    send_uniform(24'hFFFFFF);
    send_uniform(24'h800000);
    send_uniform(24'h000001);
    send_uniform(24'hFFFFFE);
    for (int b = 0; b < 24; b += 3) send_uniform(24'd1 << b);
    send_uniform(24'h555555);
    send_uniform(24'hAAAAAA);
  endtask

  task automatic test_tolerance_zero();
    write_reg(REG_STOP_TOL, 16'd0);
    send_uniform(24'h400000);
    send_uniform(24'hFFFFFF);
    send_uniform(24'd0);
  endtask

  task automatic test_radius_extremes();
    write_reg(REG_MAX_RADIUS, 16'hFFFF);
    write_reg(REG_STOP_TOL, 16'hFFFF);
    send_uniform(24'h123456);
    send_uniform(24'hFFFFFF);
    write_reg(REG_MAX_RADIUS, 16'd0);
    send_uniform(24'h9ABCDE);
  endtask

  task automatic test_random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        write_reg(REG_MAX_RADIUS, 16'($urandom_range(0, 65535)));
        write_reg(REG_STOP_TOL, (i % 100 == 0) ? 16'($urandom_range(0, 64))
                                               : 16'($urandom_range(0, 65535)));
      end
      send_uniform(24'($urandom()));
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_input_extremes();
    test_tolerance_zero();
    test_radius_extremes();
    test_random_phase(600);
    drain_and_settle();
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// ----- cubic_kernel_radius_sampler_core.f -----
+incdir+hdl
hdl/cksr_pkg.sv
hdl/cubic_kernel_radius_sampler_core.sv
verif/tb_cubic_kernel_radius_sampler_core.sv
